// ===== src/mbq_pkg.sv =====
// Shared types, constants and arithmetic helpers for the multichannel biquad unit.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package mbq_pkg;

    localparam int LANES    = 8;
    localparam int CHANNELS = 8;
    localparam int SECTIONS = 5;
    localparam int MULS     = 5;

    typedef logic signed [15:0] t_sample;
    typedef logic signed [31:0] t_coef;
    typedef logic signed [39:0] t_word;
    typedef logic signed [47:0] t_prod;
    typedef logic signed [56:0] t_acc;
    typedef logic [2:0]         t_sec;
    typedef logic [2:0]         t_step;

    // configuration register indexes
    localparam logic CFG_NOTCH  = 1'b0;
    localparam logic CFG_ACTIVE = 1'b1;

    // section steps; steps 0..4 each start one multiply
    localparam t_step STEP_MUL_B0 = 3'd0;
    localparam t_step STEP_Y_B1   = 3'd1;
    localparam t_step STEP_ACC_A1 = 3'd2;
    localparam t_step STEP_SUB_B2 = 3'd3;
    localparam t_step STEP_W0_A2  = 3'd4;
    localparam t_step STEP_W1     = 3'd5;

    localparam t_sec SEC_LAST_NOTCH = t_sec'(SECTIONS - 1);
    localparam t_sec SEC_LAST_BAND  = t_sec'(SECTIONS - 2);

    localparam t_acc ROUND_Y = t_acc'(57'sd1 <<< 29);
    localparam t_acc ROUND_W = t_acc'(57'sd1 <<< 14);

    // per section, in step order: b0, b1, a1, b2, a2 (signed Q2.30)
    localparam t_coef C_COEF [SECTIONS][MULS] = '{
        '{ 32'sd1027080952, -32'sd2054161904, -32'sd2052132225,
           32'sd1027080952,  32'sd982447826 },
        '{ 32'sd1027080952, -32'sd2054161904, -32'sd2056191583,
           32'sd1027080952,  32'sd978392334 },
        '{ 32'sd221805083,   32'sd443610166,  -32'sd396775495,
           32'sd221805083,   32'sd210254002 },
        '{ 32'sd221805083,   32'sd443610166,  -32'sd210252177,
           32'sd221805083,   32'sd396777320 },
        '{ 32'sd1063672108, -32'sd1945371204, -32'sd1945371204,
           32'sd1063672108,  32'sd1053602393 }
    };

    // lane control from the sequencer
    typedef struct packed {
        logic  start;
        logic  run;
        t_sec  sec;
        t_step step;
    } t_lane_ctl;

    function automatic t_coef coef_of(input t_sec sec, input t_step step);
        t_coef c;
        c = '0;
        if (sec < t_sec'(SECTIONS) && step < t_step'(MULS)) begin
            c = C_COEF[sec][step];
        end
        return c;
    endfunction

    function automatic t_sample sat16(input logic signed [26:0] v);
        t_sample r;
        if (v > 27'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -27'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic t_word sat40(input logic signed [41:0] v);
        t_word r;
        if (v > 42'sh0_7f_ffff_ffff) begin
            r = {1'b0, {39{1'b1}}};
        end else if (v < -42'sh0_80_0000_0000) begin
            r = {1'b1, {39{1'b0}}};
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

    function automatic t_acc ext_prod(input t_prod p);
        return {{9{p[47]}}, p};
    endfunction

    function automatic t_acc ext_word(input t_word w);
        return {{2{w[39]}}, w, 15'b0};
    endfunction

endpackage
`default_nettype wire

// ===== src/mbq_in_if.sv =====
// Request channel carrying one time step of samples, one per channel.
// Depends on mbq_pkg for the sample type.
`default_nettype none
interface mbq_in_if;
    logic             valid;
    logic             ready;
    mbq_pkg::t_sample sample_0;
    mbq_pkg::t_sample sample_1;
    mbq_pkg::t_sample sample_2;
    mbq_pkg::t_sample sample_3;
    mbq_pkg::t_sample sample_4;
    mbq_pkg::t_sample sample_5;
    mbq_pkg::t_sample sample_6;
    mbq_pkg::t_sample sample_7;

    modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                    sample_4, sample_5, sample_6, sample_7, input ready);
    modport sink   (input valid, sample_0, sample_1, sample_2, sample_3,
                    sample_4, sample_5, sample_6, sample_7, output ready);
endinterface
`default_nettype wire

// ===== src/mbq_out_if.sv =====
// Result channel carrying one filtered sample per channel.
// Depends on mbq_pkg for the sample type.
`default_nettype none
interface mbq_out_if;
    logic             valid;
    logic             ready;
    mbq_pkg::t_sample filtered_0;
    mbq_pkg::t_sample filtered_1;
    mbq_pkg::t_sample filtered_2;
    mbq_pkg::t_sample filtered_3;
    mbq_pkg::t_sample filtered_4;
    mbq_pkg::t_sample filtered_5;
    mbq_pkg::t_sample filtered_6;
    mbq_pkg::t_sample filtered_7;

    modport source (output valid, filtered_0, filtered_1, filtered_2, filtered_3,
                    filtered_4, filtered_5, filtered_6, filtered_7, input ready);
    modport sink   (input valid, filtered_0, filtered_1, filtered_2, filtered_3,
                    filtered_4, filtered_5, filtered_6, filtered_7, output ready);
endinterface
`default_nettype wire

// ===== src/mbq_lane.sv =====
// One channel lane: a single 32x16 multiplier shared over the five biquad sections.
// Depends on mbq_pkg; stepped by mbq_seq through a t_lane_ctl struct.
`default_nettype none
module mbq_lane (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mbq_pkg::t_lane_ctl i_ctl,
    input  wire mbq_pkg::t_sample   i_sample,
    input  wire logic               i_active,
    output mbq_pkg::t_sample        o_result
);

    logic             r_en;
    mbq_pkg::t_sample r_x;
    mbq_pkg::t_sample r_y;
    mbq_pkg::t_prod   r_prod;
    mbq_pkg::t_acc    r_acc;
    mbq_pkg::t_word   r_w0 [mbq_pkg::SECTIONS];
    mbq_pkg::t_word   r_w1 [mbq_pkg::SECTIONS];

    mbq_pkg::t_coef   w_coef;
    mbq_pkg::t_sample w_opnd;
    mbq_pkg::t_prod   w_prod;
    mbq_pkg::t_acc    w_sum_y;
    mbq_pkg::t_acc    w_sum_w0;
    mbq_pkg::t_acc    w_sum_w1;
    mbq_pkg::t_sample w_y;
    mbq_pkg::t_word   w_w0;
    mbq_pkg::t_word   w_w1;

    always_comb begin
        w_coef = mbq_pkg::coef_of(i_ctl.sec, i_ctl.step);
        w_opnd = (i_ctl.step == mbq_pkg::STEP_ACC_A1 || i_ctl.step == mbq_pkg::STEP_W0_A2)
               ? r_y : r_x;
        w_prod = w_coef * w_opnd;

        w_sum_y  = mbq_pkg::ext_prod(r_prod) + mbq_pkg::ext_word(r_w0[i_ctl.sec])
                 + mbq_pkg::ROUND_Y;
        w_y      = mbq_pkg::sat16(w_sum_y[56:30]);
        w_sum_w0 = r_acc + mbq_pkg::ROUND_W;
        w_w0     = mbq_pkg::sat40(w_sum_w0[56:15]);
        w_sum_w1 = r_acc - mbq_pkg::ext_prod(r_prod) + mbq_pkg::ROUND_W;
        w_w1     = mbq_pkg::sat40(w_sum_w1[56:15]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else if (i_ctl.start) begin
            r_en <= i_active;
        end
    end

    // delay words: cleared at reset, held by inactive lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < mbq_pkg::SECTIONS; s++) begin
                r_w0[s] <= '0;
                r_w1[s] <= '0;
            end
        end else if (i_ctl.run && r_en) begin
            if (i_ctl.step == mbq_pkg::STEP_W0_A2) begin
                r_w0[i_ctl.sec] <= w_w0;
            end
            if (i_ctl.step == mbq_pkg::STEP_W1) begin
                r_w1[i_ctl.sec] <= w_w1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x <= i_sample;
        end else if (i_ctl.run) begin
            r_prod <= w_prod;
            case (i_ctl.step)
                mbq_pkg::STEP_Y_B1:   r_y   <= w_y;
                mbq_pkg::STEP_ACC_A1: r_acc <= mbq_pkg::ext_prod(r_prod)
                                             + mbq_pkg::ext_word(r_w1[i_ctl.sec]);
                mbq_pkg::STEP_SUB_B2: r_acc <= r_acc - mbq_pkg::ext_prod(r_prod);
                mbq_pkg::STEP_W0_A2:  r_acc <= mbq_pkg::ext_prod(r_prod);
                // section output feeds the next section
                mbq_pkg::STEP_W1:     r_x   <= r_y;
                default: ;
            endcase
        end
    end

    assign o_result = r_en ? r_x : '0;

endmodule
`default_nettype wire

// ===== src/mbq_seq.sv =====
// Shared sequencer: walks all lanes in lockstep through sections and steps.
// Depends on mbq_pkg for the lane control struct and step codes.
`default_nettype none
module mbq_seq (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic         i_notch,
    input  wire logic         i_out_free,
    output mbq_pkg::t_lane_ctl o_ctl,
    output logic              o_idle,
    output logic              o_done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]     r_state;
    logic [1:0]     n_state;
    mbq_pkg::t_sec  r_sec;
    mbq_pkg::t_sec  n_sec;
    mbq_pkg::t_step r_step;
    mbq_pkg::t_step n_step;
    mbq_pkg::t_sec  w_last;

    assign w_last = i_notch ? mbq_pkg::SEC_LAST_NOTCH : mbq_pkg::SEC_LAST_BAND;

    always_comb begin
        n_state = r_state;
        n_sec   = r_sec;
        n_step  = r_step;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_sec   = '0;
                    n_step  = mbq_pkg::STEP_MUL_B0;
                end
            end
            S_RUN: begin
                if (r_step == mbq_pkg::STEP_W1) begin
                    n_step = mbq_pkg::STEP_MUL_B0;
                    if (r_sec == w_last) begin
                        n_state = S_WAIT;
                    end else begin
                        n_sec = r_sec + 3'd1;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_WAIT: begin
                // hold until the output register can take the result
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sec   <= '0;
            r_step  <= mbq_pkg::STEP_MUL_B0;
        end else begin
            r_state <= n_state;
            r_sec   <= n_sec;
            r_step  <= n_step;
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_ctl.start = i_start && (r_state == S_IDLE);
    assign o_ctl.run   = (r_state == S_RUN);
    assign o_ctl.sec   = r_sec;
    assign o_ctl.step  = r_step;

endmodule
`default_nettype wire

// ===== src/multichannel_biquad_bandpass_notch_unit.sv =====
// Top level: eight filter lanes, the shared sequencer and the output merge register.
// Depends on mbq_pkg, mbq_in_if, mbq_out_if, mbq_lane and mbq_seq.
//
//   channel  | direction | handshake     | payload
//   i_in     | in        | valid/ready   | sample_0 .. sample_7
//   o_out    | out       | valid/ready   | filtered_0 .. filtered_7
//   i_cfg_*  | in        | write enable  | index 0 notch_enable, 1 active_channels
//
// A request runs each section as one step per multiply on the lane's shared
// multiplier plus one step to finish the second delay word: all sections with
// the notch, all but the last without; then the result moves to the output register.
// A new request is taken once that move is done, even while the result still waits.
// Reset (synchronous, active low) clears all delay words and sets notch on, 8 channels.
// A stalled output holds the sequencer in its wait state until the register frees up.
`default_nettype none
module multichannel_biquad_bandpass_notch_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [3:0]  i_cfg_data,
    mbq_in_if.sink           i_in,
    mbq_out_if.source        o_out
);

    logic                r_notch;
    logic [3:0]          r_active;
    logic                r_out_valid;
    mbq_pkg::t_sample    r_filt    [mbq_pkg::LANES];
    mbq_pkg::t_sample    w_samples [mbq_pkg::LANES];
    mbq_pkg::t_sample    w_results [mbq_pkg::LANES];
    mbq_pkg::t_lane_ctl  w_ctl;
    logic                w_idle;
    logic                w_done;
    logic                w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_notch  <= 1'b1;
            r_active <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mbq_pkg::CFG_NOTCH:  r_notch  <= i_cfg_data[0];
                mbq_pkg::CFG_ACTIVE: r_active <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = w_idle;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_samples[0] = i_in.sample_0;
    assign w_samples[1] = i_in.sample_1;
    assign w_samples[2] = i_in.sample_2;
    assign w_samples[3] = i_in.sample_3;
    assign w_samples[4] = i_in.sample_4;
    assign w_samples[5] = i_in.sample_5;
    assign w_samples[6] = i_in.sample_6;
    assign w_samples[7] = i_in.sample_7;

    mbq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in.valid),
        .i_notch    (r_notch),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl),
        .o_idle     (w_idle),
        .o_done     (w_done)
    );

    for (genvar l = 0; l < mbq_pkg::LANES; l++) begin : g_lane
        logic w_lane_on;
        assign w_lane_on = (l < mbq_pkg::CHANNELS) && (4'(l) < r_active);

        mbq_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_sample (w_samples[l]),
            .i_active (w_lane_on),
            .o_result (w_results[l])
        );
    end

    // merge: lanes already force inactive results to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            for (int l = 0; l < mbq_pkg::LANES; l++) begin
                r_filt[l] <= w_results[l];
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.filtered_0 = r_filt[0];
    assign o_out.filtered_1 = r_filt[1];
    assign o_out.filtered_2 = r_filt[2];
    assign o_out.filtered_3 = r_filt[3];
    assign o_out.filtered_4 = r_filt[4];
    assign o_out.filtered_5 = r_filt[5];
    assign o_out.filtered_6 = r_filt[6];
    assign o_out.filtered_7 = r_filt[7];

endmodule
`default_nettype wire
